[rtl/scsd_pkg.sv]
// Shared types, character codes and helper functions of the stepper and servo driver.
package scsd_pkg;

  // Kinds of input item.
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_STOP = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  // Parser state of the number field.
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  // Operations handed from the line parser to the motor and servo back end.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_TICK   = 3'd1,
    OP_STOP   = 3'd2,
    OP_LOAD_H = 3'd3,
    OP_LOAD_V = 3'd4,
    OP_LOAD_L = 3'd5,
    OP_LOAD_R = 3'd6,
    OP_SERVO  = 3'd7
  } op_e;

  // Codes reported on applied_command.
  localparam logic [2:0] APPLIED_NONE = 3'd0;
  localparam logic [2:0] APPLIED_H    = 3'd1;
  localparam logic [2:0] APPLIED_V    = 3'd2;
  localparam logic [2:0] APPLIED_L    = 3'd3;
  localparam logic [2:0] APPLIED_R    = 3'd4;
  localparam logic [2:0] APPLIED_S    = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;

  // Number limits.
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  // Servo scaling: pulse = 500 + angle * 2000 / 270.
  localparam logic [11:0] SERVO_BASE         = 12'd500;
  localparam logic [8:0]  SERVO_MAX_ANGLE    = 9'd270;
  localparam logic [11:0] SERVO_CLOSED_PULSE = 12'd981;
  // ceil(2^21 / 27) * 200; exact for every angle up to 270 after a shift by 21.
  localparam logic [23:0] SERVO_RECIP        = 24'd15534600;
  localparam int          SERVO_SHIFT        = 21;

  typedef struct packed {
    op_e         kind;
    logic [31:0] value;
  } op_t;

  typedef struct packed {
    logic [3:0]  horizontal_coils;
    logic [3:0]  left_coils;
    logic [3:0]  right_coils;
    logic [11:0] servo_pulse_us;
    logic [31:0] horizontal_remaining;
    logic [31:0] left_remaining;
    logic [31:0] right_remaining;
    logic [2:0]  applied_command;
  } result_t;

  // Half-step coil pattern for a phase index.
  function automatic logic [3:0] coil_pattern(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

  // Servo pulse for the low 16 bits of a line value, clamped to the maximum angle.
  function automatic logic [11:0] servo_pulse(input logic [15:0] angle_raw);
    logic [8:0]  angle;
    logic [32:0] prod;
    logic [10:0] span;
    angle = (angle_raw > 16'(SERVO_MAX_ANGLE)) ? SERVO_MAX_ANGLE : angle_raw[8:0];
    prod  = 33'(angle) * 33'(SERVO_RECIP);
    span  = prod[SERVO_SHIFT +: 11];
    return SERVO_BASE + 12'(span);
  endfunction

endpackage

[rtl/serial_command_stepper_servo_driver.sv]
// Top level of the serial command stepper and servo driver.
//
// Every accepted item (serial byte, step tick, stop or no-op) gives exactly one result, in order.
// The line parser classifies an item in the cycle it is accepted and puts an operation into
// a two-entry queue; the back end takes one operation per cycle while the result queue has room,
// updates step counts, motor phases and servo pulse, and writes the new state into a two-entry
// result queue. One item per cycle is sustained while results are popped; a result passes through
// the operation queue and then the result queue before it shows on the result ports. Each queue
// lets its side run on while the other stalls, so full rises only after both queues have filled.
module serial_command_stepper_servo_driver
  import scsd_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  horizontal_coils_o,
  output logic [3:0]  left_coils_o,
  output logic [3:0]  right_coils_o,
  output logic [11:0] servo_pulse_us_o,
  output logic [31:0] horizontal_remaining_o,
  output logic [31:0] left_remaining_o,
  output logic [31:0] right_remaining_o,
  output logic [2:0]  applied_command_o
);

  op_t     front_op;
  op_t     back_op;
  result_t back_result;
  result_t out_result;
  logic    in_accept;
  logic    op_empty;
  logic    res_full;
  logic    exec;

  assign in_accept = push && !full;
  assign exec      = !op_empty && !res_full;

  scsd_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .command_i (command_i),
    .rx_byte_i (rx_byte_i),
    .op_o      (front_op)
  );

  scsd_fifo #(
    .WIDTH($bits(op_t)),
    .DEPTH(2)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .full_o  (full),
    .wdata_i (front_op),
    .pop_i   (exec),
    .empty_o (op_empty),
    .rdata_o (back_op)
  );

  scsd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (exec),
    .op_i     (back_op),
    .result_o (back_result)
  );

  scsd_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (exec),
    .full_o  (res_full),
    .wdata_i (back_result),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_result)
  );

  assign horizontal_coils_o     = out_result.horizontal_coils;
  assign left_coils_o           = out_result.left_coils;
  assign right_coils_o          = out_result.right_coils;
  assign servo_pulse_us_o       = out_result.servo_pulse_us;
  assign horizontal_remaining_o = out_result.horizontal_remaining;
  assign left_remaining_o       = out_result.left_remaining;
  assign right_remaining_o      = out_result.right_remaining;
  assign applied_command_o      = out_result.applied_command;

endmodule

[rtl/scsd_fifo.sv]
// Small register queue used between the parser and back end and in front of the result ports.
module scsd_fifo
  import scsd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/scsd_front.sv]
// Line parser: collects serial bytes into commands and classifies every item as an operation.
module scsd_front
  import scsd_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] command_i,
  input  logic [7:0] rx_byte_i,
  output op_t        op_o
);

  localparam int PosW = $clog2(LINE_CAPACITY);

  logic [7:0]      letter_q, letter_d;
  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [31:0]     mag_q, mag_d;

  logic [35:0] mag_next;
  logic [31:0] line_value;
  logic [7:0]  letter_uc;
  logic        feed_digit;
  logic        clear_line;

  always_comb begin
    mag_next   = {mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + 36'(rx_byte_i - CH_0);
    line_value = neg_q ? (32'd0 - mag_q) : (mag_q[31] ? POS_MAX : mag_q);
    letter_uc  = (letter_q inside {[CH_LC_A:CH_LC_Z]}) ? (letter_q - CH_CASE) : letter_q;

    letter_d   = letter_q;
    pos_d      = pos_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    feed_digit = 1'b0;
    clear_line = 1'b0;
    op_o.kind  = OP_NONE;
    op_o.value = line_value;

    case (cmd_e'(command_i))
      CMD_BYTE: begin
        if (rx_byte_i == CH_NL) begin
          clear_line = 1'b1;
          if (pos_q != '0) begin
            case (letter_uc)
              CH_H:    op_o.kind = OP_LOAD_H;
              CH_V:    op_o.kind = OP_LOAD_V;
              CH_L:    op_o.kind = OP_LOAD_L;
              CH_R:    op_o.kind = OP_LOAD_R;
              CH_S:    op_o.kind = OP_SERVO;
              default: op_o.kind = OP_NONE;
            endcase
          end
        end else if (pos_q >= PosW'(LINE_CAPACITY - 1)) begin
          // A full line is dropped together with the byte that overflowed it.
          clear_line = 1'b1;
        end else if (rx_byte_i != CH_CR) begin
          pos_d = pos_q + 1'b1;
          if (pos_q == '0) begin
            letter_d = rx_byte_i;
          end else begin
            case (phase_q)
              PH_SKIP: begin
                if (rx_byte_i inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_NL, CH_CR}) begin
                  phase_d = PH_SKIP;
                end else if (rx_byte_i inside {CH_PLUS, CH_MINUS}) begin
                  neg_d   = (rx_byte_i == CH_MINUS);
                  phase_d = PH_DIGITS;
                end else begin
                  // The first non-blank, non-sign byte is already part of the digits.
                  feed_digit = 1'b1;
                end
              end
              PH_DIGITS: feed_digit = 1'b1;
              default:   phase_d = phase_q;
            endcase
            if (feed_digit) begin
              if (rx_byte_i inside {[CH_0:CH_9]}) begin
                phase_d = PH_DIGITS;
                mag_d   = (mag_next > 36'(MAG_LIMIT)) ? MAG_LIMIT : mag_next[31:0];
              end else begin
                phase_d = PH_DONE;
              end
            end
          end
        end
      end
      CMD_TICK: op_o.kind = OP_TICK;
      CMD_STOP: op_o.kind = OP_STOP;
      default:  op_o.kind = OP_NONE;
    endcase

    if (clear_line) begin
      letter_d = '0;
      pos_d    = '0;
      phase_d  = PH_SKIP;
      neg_d    = 1'b0;
      mag_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q <= '0;
      pos_q    <= '0;
      phase_q  <= PH_SKIP;
      neg_q    <= 1'b0;
      mag_q    <= '0;
    end else if (accept_i) begin
      letter_q <= letter_d;
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
    end
  end

endmodule

[rtl/scsd_back.sv]
// Back end: holds step counts, motor phases and servo pulse; does one operation a cycle on exec_i.
module scsd_back
  import scsd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    exec_i,
  input  op_t     op_i,
  output result_t result_o
);

  logic [31:0] remain_q [3];
  logic [31:0] remain_d [3];
  logic [2:0]  idx_q [3];
  logic [2:0]  idx_d [3];
  logic [3:0]  coils_q [3];
  logic [3:0]  coils_d [3];
  logic [11:0] servo_q, servo_d;
  logic [2:0]  applied;
  logic        forward;
  logic        turn_up;

  always_comb begin
    servo_d = servo_q;
    applied = APPLIED_NONE;
    forward = 1'b0;
    turn_up = 1'b0;
    for (int m = 0; m < 3; m++) begin
      remain_d[m] = remain_q[m];
      idx_d[m]    = idx_q[m];
      coils_d[m]  = coils_q[m];
    end

    case (op_i.kind)
      OP_TICK: begin
        for (int m = 0; m < 3; m++) begin
          if (remain_q[m] != '0) begin
            forward = !remain_q[m][31];
            // The right vertical motor is mounted mirrored.
            turn_up = (m == 2) ? !forward : forward;
            idx_d[m]    = turn_up ? idx_q[m] + 3'd1 : idx_q[m] - 3'd1;
            coils_d[m]  = coil_pattern(idx_d[m]);
            remain_d[m] = forward ? remain_q[m] - 32'd1 : remain_q[m] + 32'd1;
          end
        end
      end
      OP_STOP: begin
        for (int m = 0; m < 3; m++) begin
          remain_d[m] = '0;
        end
        servo_d = SERVO_CLOSED_PULSE;
      end
      OP_LOAD_H: begin
        remain_d[0] = op_i.value;
        applied     = APPLIED_H;
      end
      OP_LOAD_V: begin
        remain_d[1] = op_i.value;
        remain_d[2] = op_i.value;
        applied     = APPLIED_V;
      end
      OP_LOAD_L: begin
        remain_d[1] = op_i.value;
        applied     = APPLIED_L;
      end
      OP_LOAD_R: begin
        remain_d[2] = op_i.value;
        applied     = APPLIED_R;
      end
      OP_SERVO: begin
        servo_d = servo_pulse(op_i.value[15:0]);
        applied = APPLIED_S;
      end
      default: applied = APPLIED_NONE;
    endcase

    result_o.horizontal_coils     = coils_d[0];
    result_o.left_coils           = coils_d[1];
    result_o.right_coils          = coils_d[2];
    result_o.servo_pulse_us       = servo_d;
    result_o.horizontal_remaining = remain_d[0];
    result_o.left_remaining       = remain_d[1];
    result_o.right_remaining      = remain_d[2];
    result_o.applied_command      = applied;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < 3; m++) begin
        remain_q[m] <= '0;
        idx_q[m]    <= '0;
        coils_q[m]  <= '0;
      end
      servo_q <= SERVO_CLOSED_PULSE;
    end else if (exec_i) begin
      for (int m = 0; m < 3; m++) begin
        remain_q[m] <= remain_d[m];
        idx_q[m]    <= idx_d[m];
        coils_q[m]  <= coils_d[m];
      end
      servo_q <= servo_d;
    end
  end

endmodule
